>>> rtl/lbc_pkg.sv
// Shared types and constants for the LRU block cache.
// Holds the state machine states, field codes and the controller/datapath structs.
// No dependencies.
`default_nettype none
package lbc_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int BLOCK_WORDS_DEF = 32;
  localparam int CFG_W           = 9;
  localparam int STAMP_W         = 32;
  localparam int DISK_W          = 4;
  localparam int BLK_W           = 8;
  localparam int POS_W           = 5;
  localparam int DATA_W          = 64;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_OFF     = 2'd3
  } status_t;

  typedef enum logic {
    REG_CACHE_ON = 1'b0,
    REG_ENTRIES  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_EXEC,
    S_RESP,
    S_RD,
    S_LD
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic exec;
    logic resp_load;
    logic rd_issue;
    logic word_load;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic exec_read;
    logic exec_resp;
    logic out_free;
    logic word_last;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/lbc_ctrl.sv
// Controller state machine of the LRU block cache.
// Sequences accept, tag scan, execute and result delivery; uses lbc_pkg.
`default_nettype none
module lbc_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  lbc_pkg::sts_t     sts,
  output lbc_pkg::cmd_t     cmd
);
  import lbc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_PREP;
      S_PREP: state_next = sts.need_scan ? S_SCAN : S_EXEC;
      S_SCAN: if (sts.scan_done) state_next = S_EXEC;
      S_EXEC: begin
        if (sts.exec_read) state_next = S_RD;
        else if (sts.exec_resp) state_next = S_RESP;
        else state_next = S_IDLE;
      end
      S_RESP: if (sts.out_free) state_next = S_IDLE;
      S_RD:   state_next = S_LD;
      S_LD: begin
        if (sts.out_free) state_next = sts.word_last ? S_IDLE : S_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == S_IDLE);
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.scan_start = (state == S_PREP) && sts.need_scan;
    cmd.exec       = (state == S_EXEC);
    cmd.resp_load  = (state == S_RESP) && sts.out_free;
    cmd.rd_issue   = (state == S_RD);
    cmd.word_load  = (state == S_LD) && sts.out_free;
  end

endmodule
`default_nettype wire

>>> rtl/lbc_dpath.sv
// Datapath of the LRU block cache: config registers, tag and stamp memories,
// sequential tag scan, block store and the output register. Uses lbc_pkg.
`default_nettype none
module lbc_dpath #(
  parameter int MAX_ENTRIES = lbc_pkg::MAX_ENTRIES_DEF,
  parameter int BLOCK_WORDS = lbc_pkg::BLOCK_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_idx,
  input  wire logic [lbc_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic [1:0]                  mode,
  input  wire logic [lbc_pkg::DISK_W-1:0]  disk_id,
  input  wire logic [lbc_pkg::BLK_W-1:0]   block_id,
  input  wire logic [lbc_pkg::POS_W-1:0]   word_pos,
  input  wire logic [lbc_pkg::DATA_W-1:0]  word_in,
  input  wire logic                        final_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       status,
  output logic [lbc_pkg::DATA_W-1:0]       word_out,
  output logic [lbc_pkg::POS_W-1:0]        word_pos_out,
  output logic                             last_out,
  input  lbc_pkg::cmd_t                    cmd,
  output lbc_pkg::sts_t                    sts
);
  import lbc_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int KW = $clog2(BLOCK_WORDS + 1);
  localparam int AW = $clog2(MAX_ENTRIES * BLOCK_WORDS);
  localparam int TW = DISK_W + BLK_W;

  // Configuration.
  logic             cache_on;
  logic [CFG_W-1:0] entries_in_use;
  logic [CW-1:0]    n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_on       <= 1'b0;
      entries_in_use <= CFG_W'(2);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_CACHE_ON: cache_on <= cfg_data[0];
        REG_ENTRIES:  entries_in_use <= cfg_data;
        default:      cache_on <= cache_on;
      endcase
    end
  end

  always_comb begin
    if (int'(entries_in_use) < 2) n_eff = CW'(2);
    else if (int'(entries_in_use) > MAX_ENTRIES) n_eff = CW'(MAX_ENTRIES);
    else n_eff = CW'(entries_in_use);
  end

  // Captured item.
  mode_t             mode_r;
  logic [DISK_W-1:0] disk_r;
  logic [BLK_W-1:0]  blk_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] word_r;
  logic              fin_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(mode);
      disk_r <= disk_id;
      blk_r  <= block_id;
      pos_r  <= word_pos;
      word_r <= word_in;
      fin_r  <= final_word;
    end
  end

  // Entry state: valid bits in flops, tags and stamps in memories.
  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [TW-1:0]          tag_mem   [MAX_ENTRIES];
  logic [STAMP_W-1:0]     stamp_mem [MAX_ENTRIES];
  logic [DATA_W-1:0]      store_mem [MAX_ENTRIES * BLOCK_WORDS];
  logic [STAMP_W-1:0]     use_clock;
  logic [IW-1:0]          run_entry;
  status_t                run_result;

  // Scan: one entry read per cycle, compared in the cycle after its read.
  logic               scan_busy;
  logic [CW-1:0]      scan_addr;
  logic               rd_vld;
  logic [IW-1:0]      rd_idx;
  logic [TW-1:0]      tag_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               hit_found, free_found;
  logic [IW-1:0]      hit_idx, free_idx, min_idx;
  logic [STAMP_W-1:0] min_stamp;
  logic               issue;

  assign issue = scan_busy && (scan_addr < n_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
      rd_vld    <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_busy <= 1'b1;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (sts.scan_done) scan_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr  <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (issue) begin
        tag_q     <= tag_mem[scan_addr[IW-1:0]];
        stamp_q   <= stamp_mem[scan_addr[IW-1:0]];
        rd_idx    <= scan_addr[IW-1:0];
        scan_addr <= scan_addr + CW'(1);
      end
      if (rd_vld) begin
        if (entry_valid[rd_idx] && tag_q == {disk_r, blk_r} && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= rd_idx;
        end
        if (!entry_valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        // Strict compare keeps the lowest index on a tie.
        if (rd_idx == '0 || stamp_q < min_stamp) begin
          min_stamp <= stamp_q;
          min_idx   <= rd_idx;
        end
      end
    end
  end

  // Execute decision for the captured item.
  status_t       rr_eff, resp_c;
  logic [IW-1:0] re_eff, touch_idx, pick;
  logic          touch_en, alloc, store_we, exec_read, exec_resp;

  assign pick = free_found ? free_idx : min_idx;

  always_comb begin
    rr_eff    = run_result;
    re_eff    = run_entry;
    touch_en  = 1'b0;
    touch_idx = hit_idx;
    alloc     = 1'b0;
    store_we  = 1'b0;
    exec_read = 1'b0;
    exec_resp = 1'b0;
    resp_c    = ST_MISS;
    if (mode_r == MODE_UNUSED) begin
      exec_resp = 1'b1;
    end else if (!cache_on) begin
      resp_c = ST_OFF;
      if (mode_r == MODE_LOOKUP) begin
        exec_resp = 1'b1;
      end else begin
        rr_eff    = ST_OFF;
        exec_resp = fin_r;
      end
    end else if (mode_r == MODE_LOOKUP) begin
      if (hit_found) begin
        touch_en  = 1'b1;
        exec_read = 1'b1;
      end else begin
        exec_resp = 1'b1;
      end
    end else begin
      if (pos_r == '0) begin
        if (mode_r == MODE_INSERT) begin
          if (hit_found) begin
            touch_en = 1'b1;
            rr_eff   = ST_PRESENT;
          end else begin
            alloc     = 1'b1;
            touch_en  = 1'b1;
            touch_idx = pick;
            re_eff    = pick;
            rr_eff    = ST_OK;
          end
        end else if (hit_found) begin
          touch_en = 1'b1;
          re_eff   = hit_idx;
          rr_eff   = ST_OK;
        end else begin
          rr_eff = ST_MISS;
        end
      end
      store_we  = (rr_eff == ST_OK) && (int'(pos_r) < BLOCK_WORDS);
      exec_resp = fin_r;
      resp_c    = rr_eff;
    end
  end

  // Block word counter for a lookup hit.
  logic [KW-1:0] k;
  status_t       resp_st;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_W-1:0] store_q;

  assign waddr = AW'(re_eff) * AW'(BLOCK_WORDS) + AW'(pos_r);
  assign raddr = AW'(hit_idx) * AW'(BLOCK_WORDS) + AW'(k);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      use_clock   <= '0;
      run_entry   <= '0;
      run_result  <= ST_OK;
    end else if (cmd.exec) begin
      run_result <= rr_eff;
      run_entry  <= re_eff;
      if (touch_en) use_clock <= use_clock + STAMP_W'(1);
      if (alloc) entry_valid[pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      resp_st <= resp_c;
      k       <= '0;
      if (touch_en) stamp_mem[touch_idx] <= use_clock + STAMP_W'(1);
      if (alloc) tag_mem[pick] <= {disk_r, blk_r};
      if (store_we) store_mem[waddr] <= word_r;
    end
    if (cmd.rd_issue) store_q <= store_mem[raddr];
    if (cmd.word_load) k <= k + KW'(1);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp_load || cmd.word_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      status       <= resp_st;
      word_out     <= '0;
      word_pos_out <= '0;
      last_out     <= 1'b1;
    end else if (cmd.word_load) begin
      status       <= ST_OK;
      word_out     <= store_q;
      word_pos_out <= POS_W'(k);
      last_out     <= (int'(k) == BLOCK_WORDS - 1);
    end
  end

  always_comb begin
    sts.need_scan = cache_on && (mode_r != MODE_UNUSED)
                    && (mode_r == MODE_LOOKUP || pos_r == '0);
    sts.scan_done = scan_busy && !issue && !rd_vld;
    sts.exec_read = exec_read;
    sts.exec_resp = exec_resp;
    sts.out_free  = !out_valid || out_ready;
    sts.word_last = (int'(k) == BLOCK_WORDS - 1);
  end

endmodule
`default_nettype wire

>>> rtl/lru_block_cache.sv
// Top level of the fully associative LRU block cache.
// Instantiates lbc_ctrl and lbc_dpath; uses lbc_pkg.
//
//  Channel | Signals                                           | Direction
//  in      | in_valid/in_ready, mode, disk_id, block_id,       | into block
//          | word_pos, word_in, final_word                     |
//  out     | out_valid/out_ready, status, word_out,            | out of block
//          | word_pos_out, last_out                            |
//  cfg     | cfg_we, cfg_idx, cfg_data                         | into block
//
// With the cache on, a lookup or a word at position 0 of an insert or update run scans
// the tag memory one entry per cycle; other run words skip the scan. A lookup hit then
// reads its block out word by word, each word waiting for a free output register.
// Reset clears the valid bits at once, so there is no clearing pass.
// A full output register lets a new transaction in; delivery then waits on out_ready.
`default_nettype none
module lru_block_cache #(
  parameter int MAX_ENTRIES = lbc_pkg::MAX_ENTRIES_DEF,
  parameter int BLOCK_WORDS = lbc_pkg::BLOCK_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_idx,
  input  wire logic [lbc_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  mode,
  input  wire logic [lbc_pkg::DISK_W-1:0]  disk_id,
  input  wire logic [lbc_pkg::BLK_W-1:0]   block_id,
  input  wire logic [lbc_pkg::POS_W-1:0]   word_pos,
  input  wire logic [lbc_pkg::DATA_W-1:0]  word_in,
  input  wire logic                        final_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       status,
  output logic [lbc_pkg::DATA_W-1:0]       word_out,
  output logic [lbc_pkg::POS_W-1:0]        word_pos_out,
  output logic                             last_out
);
  import lbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbc_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .disk_id      (disk_id),
    .block_id     (block_id),
    .word_pos     (word_pos),
    .word_in      (word_in),
    .final_word   (final_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .word_out     (word_out),
    .word_pos_out (word_pos_out),
    .last_out     (last_out),
    .cmd          (cmd),
    .sts          (sts)
  );

  // One transaction is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in work");

  // Results are only loaded into a free output register.
  a_resp_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.resp_load || cmd.word_load) |-> sts.out_free)
    else $error("result loaded over an undelivered result");

  // A scan cannot finish in the cycle right after it starts.
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |=> !sts.scan_done)
    else $error("scan finished without reading any entry");

  // A loaded result shows up as valid in the next cycle.
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (cmd.resp_load || cmd.word_load) |=> out_valid)
    else $error("loaded result not presented");

endmodule
`default_nettype wire

>>> dv/lru_block_cache_tb.sv
// Self-checking testbench for the LRU block cache: random and directed
// lookup, insert and update traffic checked against an in-bench cache model.
// Depends on rtl/lbc_pkg.sv and rtl/lru_block_cache.sv.
`timescale 1ns / 1ps
module lru_block_cache_tb;
  import lbc_pkg::*;

  localparam int NENT   = 256;
  localparam int NWORDS = 32;
  localparam int SETTLE = 300;

  typedef struct {
    mode_t       mode;
    logic [3:0]  disk;
    logic [7:0]  blk;
    logic [4:0]  pos;
    logic [63:0] word;
    logic        fin;
  } access_t;

  typedef struct {
    status_t     st;
    logic [63:0] word;
    logic [4:0]  pos;
    logic        last;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_idx = 0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [DISK_W-1:0] disk_id = '0;
  logic [BLK_W-1:0] block_id = '0;
  logic [POS_W-1:0] word_pos = '0;
  logic [DATA_W-1:0] word_in = '0;
  logic final_word = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic [DATA_W-1:0] word_out;
  logic [POS_W-1:0] word_pos_out;
  logic last_out;

  lru_block_cache dut (.*);

  always #2 clk = ~clk;

  // Cache model state.
  logic        m_on;
  int          m_count;
  logic        m_valid [NENT];
  logic [3:0]  m_dtag [NENT];
  logic [7:0]  m_btag [NENT];
  logic [31:0] m_stamp [NENT];
  logic [31:0] m_clock;
  logic [63:0] m_store [NENT*NWORDS];
  logic [31:0] m_written [NENT];
  int          m_run_entry;
  status_t     m_run_status;

  access_t pending_q[$];
  answer_t answer_q[$];
  int errors = 0;

  function automatic int live_entries();
    return (m_count < 2) ? 2 : ((m_count > NENT) ? NENT : m_count);
  endfunction

  function automatic int find_entry(logic [3:0] d, logic [7:0] b);
    for (int i = 0; i < live_entries(); i++)
      if (m_valid[i] && m_dtag[i] == d && m_btag[i] == b) return i;
    return -1;
  endfunction

  function automatic void touch(int e);
    m_clock = m_clock + 1;
    m_stamp[e] = m_clock;
  endfunction

  function automatic void push_answer(status_t st, logic [63:0] w, logic [4:0] p, logic l);
    answer_t a;
    a.st = st; a.word = w; a.pos = p; a.last = l;
    answer_q.push_back(a);
  endfunction

  // Applies one access to the model and queues the answers it produces.
  function automatic void predict_access(access_t it);
    int hit;
    int pick;
    int n;
    n = live_entries();
    if (it.mode == MODE_UNUSED) begin
      push_answer(ST_MISS, '0, '0, 1'b1);
      return;
    end
    if (!m_on) begin
      if (it.mode != MODE_LOOKUP) m_run_status = ST_OFF;
      if (it.mode == MODE_LOOKUP || it.fin) push_answer(ST_OFF, '0, '0, 1'b1);
      return;
    end
    if (it.mode == MODE_LOOKUP) begin
      hit = find_entry(it.disk, it.blk);
      if (hit < 0) begin
        push_answer(ST_MISS, '0, '0, 1'b1);
        return;
      end
      touch(hit);
      for (int k = 0; k < NWORDS; k++)
        push_answer(ST_OK, m_store[hit*NWORDS+k], k[4:0], k == NWORDS-1);
      return;
    end
    if (it.pos == 0) begin
      hit = find_entry(it.disk, it.blk);
      if (it.mode == MODE_INSERT) begin
        if (hit >= 0) begin
          touch(hit);
          m_run_status = ST_PRESENT;
        end else begin
          pick = -1;
          for (int k = 0; k < n && pick < 0; k++)
            if (!m_valid[k]) pick = k;
          if (pick < 0) begin
            pick = 0;
            for (int k = 1; k < n; k++)
              if (m_stamp[k] < m_stamp[pick]) pick = k;
          end
          m_valid[pick] = 1'b1;
          m_dtag[pick] = it.disk;
          m_btag[pick] = it.blk;
          touch(pick);
          m_run_entry = pick;
          m_run_status = ST_OK;
        end
      end else if (hit >= 0) begin
        touch(hit);
        m_run_entry = hit;
        m_run_status = ST_OK;
      end else begin
        m_run_status = ST_MISS;
      end
    end
    if (m_run_status == ST_OK) begin
      m_store[m_run_entry*NWORDS+it.pos] = it.word;
      m_written[m_run_entry][it.pos] = 1'b1;
    end
    if (it.fin) push_answer(m_run_status, '0, '0, 1'b1);
  endfunction

  // A lookup that would return a partly written block is turned into an
  // unused-mode access so that no unwritten word is ever read back.
  function automatic void queue_access(access_t it);
    int hit;
    if (it.mode == MODE_LOOKUP && m_on) begin
      hit = find_entry(it.disk, it.blk);
      if (hit >= 0 && m_written[hit] != '1) it.mode = MODE_UNUSED;
    end
    predict_access(it);
    pending_q.push_back(it);
  endfunction

  function automatic void queue_run(mode_t md, logic [3:0] d, logic [7:0] b,
                                    int start, int len, logic ones);
    access_t it;
    for (int p = 0; p < len; p++) begin
      it.mode = md; it.disk = d; it.blk = b;
      it.pos = 5'(start + p);
      it.word = ones ? '1 : {$urandom, $urandom};
      it.fin = (p == len - 1);
      queue_access(it);
    end
  endfunction

  function automatic void queue_lookup(logic [3:0] d, logic [7:0] b);
    access_t it;
    it.mode = MODE_LOOKUP; it.disk = d; it.blk = b;
    it.pos = 5'($urandom); it.word = {$urandom, $urandom}; it.fin = 1'($urandom);
    queue_access(it);
  endfunction

  function automatic void queue_random(int target);
    int base;
    int r;
    int start;
    int len;
    logic [3:0] d;
    logic [7:0] b;
    access_t it;
    base = pending_q.size();
    while (pending_q.size() - base < target) begin
      // Keys mostly come from a small pool so that hits and evictions occur.
      if ($urandom_range(0, 4) == 0) begin
        d = 4'($urandom); b = 8'($urandom);
      end else begin
        r = $urandom_range(0, 5);
        d = (r == 5) ? 4'hf : r[3:0];
        b = (r == 5) ? 8'hff : 8'(r * 37);
      end
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NWORDS) : NWORDS;
      if (r < 35) queue_run(MODE_INSERT, d, b, 0, len, 1'b0);
      else if (r < 55) queue_run(MODE_UPDATE, d, b, 0, len, 1'b0);
      else if (r < 85) queue_lookup(d, b);
      else if (r < 92) begin
        it.mode = MODE_UNUSED; it.disk = d; it.blk = b; it.pos = 5'($urandom);
        it.word = {$urandom, $urandom}; it.fin = 1'($urandom);
        queue_access(it);
      end else begin
        start = $urandom_range(1, NWORDS - 1);
        queue_run($urandom_range(0, 1) ? MODE_INSERT : MODE_UPDATE, d, b, start,
                  $urandom_range(1, NWORDS - start), 1'b0);
      end
    end
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CACHE_ON) m_on = value[0];
    else m_count = value[CFG_W-1:0];
  endtask

  // Driver: bursts of transactions separated by random gaps.
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    access_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        it = pending_q.pop_front();
        in_valid <= 1'b1;
        mode <= it.mode;
        disk_id <= it.disk;
        block_id <= it.blk;
        word_pos <= it.pos;
        word_in <= it.word;
        final_word <= it.fin;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls follow a randomly chosen pattern: always ready, ready at random, or seldom ready.
  int ready_cycle = 0;
  int ready_style = 0;
  always @(posedge clk) begin
    ready_cycle++;
    if (ready_cycle % 100 == 0) ready_style = $urandom_range(0, 2);
    case (ready_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Monitor: every result transaction is checked against the oldest answer.
  always @(posedge clk) begin
    answer_t a;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d word %h", status, word_out);
      end else begin
        a = answer_q.pop_front();
        if (status !== a.st || word_out !== a.word || word_pos_out !== a.pos ||
            last_out !== a.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st %0d w %h p %0d l %0d, got st %0d w %h p %0d l %0d",
                     a.st, a.word, a.pos, a.last, status, word_out, word_pos_out, last_out);
        end
      end
    end
  end

  initial begin
    access_t it;
    m_on = 1'b0;
    m_count = 2;
    m_clock = '0;
    m_run_entry = 0;
    m_run_status = ST_OK;
    for (int i = 0; i < NENT; i++) begin
      m_valid[i] = 1'b0; m_dtag[i] = '0; m_btag[i] = '0;
      m_stamp[i] = '0; m_written[i] = '0;
    end
    for (int i = 0; i < NENT*NWORDS; i++) m_store[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: disabled cache, unused mode, then mostly single-word runs at the extremes.
    queue_lookup(4'hf, 8'hff);
    queue_run(MODE_INSERT, 4'h0, 8'h00, 0, 2, 1'b1);
    queue_run(MODE_UPDATE, 4'hf, 8'hff, 5, 1, 1'b0);
    it.mode = MODE_UNUSED; it.disk = '1; it.blk = '1; it.pos = '1; it.word = '1; it.fin = 1;
    queue_access(it);
    wait_idle();
    write_reg(REG_CACHE_ON, 1);
    write_reg(REG_ENTRIES, 2);
    queue_lookup(4'h0, 8'h00);
    queue_run(MODE_UPDATE, 4'h0, 8'h00, 0, 1, 1'b0);
    queue_run(MODE_INSERT, 4'h0, 8'h00, 0, 1, 1'b0);
    queue_run(MODE_INSERT, 4'h0, 8'h00, 0, 1, 1'b1);
    queue_run(MODE_INSERT, 4'hf, 8'hff, 0, 1, 1'b1);
    queue_run(MODE_UPDATE, 4'hf, 8'hff, 0, 2, 1'b1);
    queue_run(MODE_INSERT, 4'h3, 8'h10, 0, 1, 1'b0);
    queue_run(MODE_UPDATE, 4'h3, 8'h10, 31, 1, 1'b1);
    queue_run(MODE_UPDATE, 4'h9, 8'h01, 0, 1, 1'b0);
    queue_run(MODE_INSERT, 4'h9, 8'h01, 7, 1, 1'b0);
    queue_lookup(4'h3, 8'h10);
    queue_random(20);
    wait_idle();
    write_reg(REG_ENTRIES, 256);
    queue_random(20);
    wait_idle();
    write_reg(REG_ENTRIES, 7);
    queue_random(20);
    wait_idle();
    write_reg(REG_CACHE_ON, 0);
    queue_random(6);
    wait_idle();
    write_reg(REG_CACHE_ON, 1);
    write_reg(REG_ENTRIES, 2);
    queue_random(15);
    wait_idle();

    if (errors == 0 && answer_q.size() == 0) begin
      $display("lru_block_cache regression: pass");
    end else begin
      $display("lru_block_cache regression: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("lru_block_cache regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/lbc_pkg.sv
rtl/lbc_ctrl.sv
rtl/lbc_dpath.sv
rtl/lru_block_cache.sv
dv/lru_block_cache_tb.sv
